@@ rtl/bra_pkg.sv @@
package bra_pkg;

  // Field widths
  localparam int TGT_W     = 34;
  localparam int DEN_W     = 30;
  localparam int ITER_W    = 7;
  localparam int FRAC_BITS = 32;

  // Divider: 64-bit dividend, quotient limited to 31 bits plus overflow flag
  localparam int DIV_W = 64;
  localparam int QUO_W = 31;
  localparam int SH_W  = DIV_W + QUO_W;
  localparam int CNT_W = $clog2(QUO_W);

  localparam logic [ITER_W-1:0] MAX_ITER   = 7'd100;
  localparam logic [DEN_W-1:0]  MAXDEN_RST = 30'd1048575;

  // Register map (byte addresses)
  localparam logic [1:0] ADDR_MAXDEN = 2'd0;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_BD,
    OP_MUL_B,
    OP_MUL_D,
    OP_GAP,
    OP_MUL_GM,
    OP_DIV_N,
    OP_DIV_CAP,
    OP_CLAMP,
    OP_MUL_NN,
    OP_ADD_N,
    OP_ADD_D,
    OP_FIN_B,
    OP_FIN_LO,
    OP_FIN_HI,
    OP_FIN_BC,
    OP_FIN_AD,
    OP_FIN_PICK,
    OP_RES_KEPT,
    OP_RES_ABOVE,
    OP_RES_BELOW,
    OP_PUSH
  } op_e;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic tgt_neg;
    logic tgt_big;
    logic bound_hit;
    logic sign_exit;
    logic small_gap;
    logic div_busy;
  } status_t;

endpackage

@@ rtl/bra_div.sv @@
module bra_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bra_pkg::DIV_W-1:0]     dividend_i,
  input  logic [bra_pkg::DIV_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [bra_pkg::QUO_W-1:0]     quo_o,
  output logic                          ovf_o
);

  logic                          busy_q, busy_d;
  logic [bra_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [bra_pkg::DIV_W-1:0]     rem_q;
  logic [bra_pkg::SH_W-1:0]      sh_q;
  logic [bra_pkg::QUO_W-1:0]     quo_q;
  logic                          ovf_q;
  logic                          ge;

  // Trial subtract of the shifted divisor
  assign ge = {{bra_pkg::QUO_W{1'b0}}, rem_q} >= sh_q;

  // Step counter: one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = bra_pkg::CNT_W'(bra_pkg::QUO_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Restoring division with quotient bound check at start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      sh_q  <= {1'b0, divisor_i, {(bra_pkg::QUO_W-1){1'b0}}};
      ovf_q <= {{bra_pkg::QUO_W{1'b0}}, dividend_i} >= {divisor_i, {bra_pkg::QUO_W{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - sh_q[bra_pkg::DIV_W-1:0];
      end
      quo_q <= {quo_q[bra_pkg::QUO_W-2:0], ge};
      sh_q  <= sh_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

@@ rtl/bra_dp.sv @@
module bra_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bra_pkg::op_e                  op_i,
  input  logic [bra_pkg::TGT_W-1:0]     target_i,
  input  logic [bra_pkg::DEN_W-1:0]     maxden_i,
  output bra_pkg::status_t              sts_o,
  output logic [bra_pkg::DEN_W-1:0]     numerator_o,
  output logic [bra_pkg::DEN_W-1:0]     denominator_o,
  output logic [bra_pkg::ITER_W-1:0]    iteration_count_o,
  output logic [1:0]                    status_o
);

  localparam int DW = bra_pkg::DEN_W;
  localparam int FB = bra_pkg::FRAC_BITS;

  // Working state
  logic [bra_pkg::TGT_W-1:0]   raw_q;
  logic [DW-1:0]               m_q, a_q, b_q, c_q, d_q;
  logic [bra_pkg::ITER_W-1:0]  ii_q;
  logic                        left_q;
  logic [63:0]                 p_q;
  logic [62:0]                 tb_q, g_q, h_q;
  logic [bra_pkg::QUO_W-1:0]   n_q;
  logic                        novf_q;
  logic [DW-1:0]               nn_q;
  logic [93:0]                 acc_q;
  logic [60:0]                 rhs_q;
  // Pending result and output beat
  logic [DW-1:0]               rn_q, rd_q, on_q, od_q;
  logic [bra_pkg::ITER_W-1:0]  ri_q, oi_q;
  logic [1:0]                  rs_q, os_q;

  logic [32:0]                 t33;
  logic [DW:0]                 ac, bd;
  logic                        iter_over;
  logic [DW-1:0]               kn, kd, md;
  logic [32:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [64:0]                 prod;
  logic [62:0]                 af, cf, td, g_new, h_new;
  logic                        tb_lt_af, cf_lt_td;
  logic [66:0]                 x10;
  logic                        div_start, div_busy, div_ovf;
  logic [bra_pkg::DIV_W-1:0]   div_num, div_den;
  logic [bra_pkg::QUO_W-1:0]   quo;
  logic [bra_pkg::QUO_W-1:0]   n0, n1;
  logic [DW-1:0]               cap, nn_new;
  logic [60:0]                 rhs_sum;
  logic                        fin_lt;

  assign t33       = raw_q[32:0];
  assign ac        = {1'b0, a_q} + {1'b0, c_q};
  assign bd        = {1'b0, b_q} + {1'b0, d_q};
  assign iter_over = ii_q > bra_pkg::MAX_ITER;

  // Kept endpoint is the side the target lies next to
  assign kn = left_q ? a_q : c_q;
  assign kd = left_q ? b_q : d_q;
  assign md = left_q ? d_q : b_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      bra_pkg::OP_MUL_BD: begin
        mul_a = t33;                 mul_b = {1'b0, bd};
      end
      bra_pkg::OP_MUL_B, bra_pkg::OP_FIN_B: begin
        mul_a = t33;                 mul_b = {2'b0, b_q};
      end
      bra_pkg::OP_MUL_D: begin
        mul_a = t33;                 mul_b = {2'b0, d_q};
      end
      bra_pkg::OP_MUL_GM: begin
        mul_a = {1'b0, g_q[31:0]};   mul_b = {2'b0, m_q};
      end
      bra_pkg::OP_MUL_NN: begin
        mul_a = {3'b0, nn_q};        mul_b = {2'b0, kn};
      end
      bra_pkg::OP_ADD_N: begin
        mul_a = {3'b0, nn_q};        mul_b = {2'b0, kd};
      end
      bra_pkg::OP_FIN_LO: begin
        mul_a = {1'b0, p_q[31:0]};   mul_b = {2'b0, d_q};
      end
      bra_pkg::OP_FIN_HI: begin
        mul_a = {2'b0, tb_q[62:32]}; mul_b = {2'b0, d_q};
      end
      bra_pkg::OP_FIN_BC: begin
        mul_a = {3'b0, b_q};         mul_b = {2'b0, c_q};
      end
      bra_pkg::OP_FIN_AD: begin
        mul_a = {3'b0, a_q};         mul_b = {2'b0, d_q};
      end
      default: begin
        mul_a = '0;                  mul_b = '0;
      end
    endcase
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  // Gaps on both sides, p_q holds t*d here
  assign td       = p_q[62:0];
  assign af       = {1'b0, a_q, {FB{1'b0}}};
  assign cf       = {1'b0, c_q, {FB{1'b0}}};
  assign tb_lt_af = tb_q < af;
  assign cf_lt_td = cf < td;
  assign g_new    = left_q ? (tb_q - af) : (cf - td);
  assign h_new    = left_q ? (cf_lt_td ? '0 : cf - td) : (tb_lt_af ? '0 : tb_q - af);

  // 10*m*gap, p_q holds gap*m
  assign x10 = 67'({p_q, 3'b0}) + 67'({p_q, 1'b0});

  // Divider feeds: run length, then its cap
  assign div_start = (op_i == bra_pkg::OP_DIV_N) || (op_i == bra_pkg::OP_DIV_CAP);
  assign div_num   = (op_i == bra_pkg::OP_DIV_N) ? {1'b0, h_q} : {34'b0, m_q - md};
  assign div_den   = (op_i == bra_pkg::OP_DIV_N) ? {1'b0, g_q} : {34'b0, kd};

  bra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .ovf_o      (div_ovf)
  );

  // Run length clamp to [1, cap]
  assign cap    = quo[DW-1:0];
  assign n0     = novf_q ? '1 : n_q;
  assign n1     = (n0 == '0) ? bra_pkg::QUO_W'(1) : n0;
  assign nn_new = (n1 > {1'b0, cap}) ? cap : n1[DW-1:0];

  // Final pick: 2*t*b*d against (b*c + a*d) * 2^FB
  assign rhs_sum = rhs_q + p_q[60:0];
  assign fin_lt  = {acc_q, 1'b0} < {2'b0, rhs_sum, {FB{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (op_i != bra_pkg::OP_NOP) begin
      p_q <= prod[63:0];
    end
    unique case (op_i)
      bra_pkg::OP_LOAD: begin
        raw_q <= target_i;
        m_q   <= (maxden_i == '0) ? DW'(1) : maxden_i;
        a_q   <= '0;
        b_q   <= DW'(1);
        c_q   <= DW'(1);
        d_q   <= DW'(1);
        ii_q  <= '0;
      end
      bra_pkg::OP_MUL_B: left_q <= p_q < {1'b0, ac, {FB{1'b0}}};
      bra_pkg::OP_MUL_D: tb_q <= p_q[62:0];
      bra_pkg::OP_GAP: begin
        g_q <= g_new;
        h_q <= h_new;
      end
      bra_pkg::OP_DIV_CAP: begin
        n_q    <= quo;
        novf_q <= div_ovf;
      end
      bra_pkg::OP_CLAMP: nn_q <= nn_new;
      bra_pkg::OP_ADD_N: begin
        if (left_q) c_q <= c_q + p_q[DW-1:0];
        else        a_q <= a_q + p_q[DW-1:0];
      end
      bra_pkg::OP_ADD_D: begin
        if (left_q) d_q <= d_q + p_q[DW-1:0];
        else        b_q <= b_q + p_q[DW-1:0];
        ii_q <= ii_q + 1'b1;
      end
      bra_pkg::OP_FIN_LO: tb_q <= p_q[62:0];
      bra_pkg::OP_FIN_HI: acc_q <= 94'(p_q);
      bra_pkg::OP_FIN_BC: acc_q <= acc_q + {p_q[61:0], {FB{1'b0}}};
      bra_pkg::OP_FIN_AD: rhs_q <= p_q[60:0];
      bra_pkg::OP_FIN_PICK: begin
        rn_q <= fin_lt ? a_q : c_q;
        rd_q <= fin_lt ? b_q : d_q;
        ri_q <= ii_q;
        rs_q <= iter_over ? bra_pkg::ST_LIMIT : bra_pkg::ST_OK;
      end
      bra_pkg::OP_RES_KEPT: begin
        rn_q <= kn;
        rd_q <= kd;
        ri_q <= ii_q;
        rs_q <= bra_pkg::ST_OK;
      end
      bra_pkg::OP_RES_ABOVE: begin
        rn_q <= DW'(1);
        rd_q <= DW'(1);
        ri_q <= '0;
        rs_q <= bra_pkg::ST_ABOVE;
      end
      bra_pkg::OP_RES_BELOW: begin
        rn_q <= '0;
        rd_q <= DW'(1);
        ri_q <= '0;
        rs_q <= bra_pkg::ST_BELOW;
      end
      bra_pkg::OP_PUSH: begin
        on_q <= rn_q;
        od_q <= rd_q;
        oi_q <= ri_q;
        os_q <= rs_q;
      end
      default: ;
    endcase
  end

  // Flags for the controller
  assign sts_o.tgt_neg   = raw_q[bra_pkg::TGT_W-1];
  assign sts_o.tgt_big   = raw_q[32] && (|raw_q[31:0]);
  assign sts_o.bound_hit = (bd > {1'b0, m_q}) || iter_over;
  assign sts_o.sign_exit = left_q ? tb_lt_af : cf_lt_td;
  assign sts_o.small_gap = (g_q[62:32] == '0) && (x10[66:32] == '0);
  assign sts_o.div_busy  = div_busy;

  assign numerator_o       = on_q;
  assign denominator_o     = od_q;
  assign iteration_count_o = oi_q;
  assign status_o          = os_q;

endmodule

@@ rtl/bra_ctrl.sv @@
module bra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bra_pkg::status_t  sts_i,
  output bra_pkg::op_e      op_o
);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_CLS  = 24'h000002,
    S_CHK  = 24'h000004,
    S_MBD  = 24'h000008,
    S_MTB  = 24'h000010,
    S_MTD  = 24'h000020,
    S_GAP  = 24'h000040,
    S_RKP  = 24'h000080,
    S_MGM  = 24'h000100,
    S_TST  = 24'h000200,
    S_DWN  = 24'h000400,
    S_DVC  = 24'h000800,
    S_DWC  = 24'h001000,
    S_CLP  = 24'h002000,
    S_MNN  = 24'h004000,
    S_ADN  = 24'h008000,
    S_ADD  = 24'h010000,
    S_FTB  = 24'h020000,
    S_FLO  = 24'h040000,
    S_FHI  = 24'h080000,
    S_FBC  = 24'h100000,
    S_FAD  = 24'h200000,
    S_FPK  = 24'h400000,
    S_OUT  = 24'h800000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   push;

  // Sequencer: one micro-op per cycle at most; it waits while the divider is busy or the output register is held
  always_comb begin
    state_d = state_q;
    op_o    = bra_pkg::OP_NOP;
    push    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = bra_pkg::OP_LOAD;
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        priority if (sts_i.tgt_neg) begin
          op_o    = bra_pkg::OP_RES_BELOW;
          state_d = S_OUT;
        end else if (sts_i.tgt_big) begin
          op_o    = bra_pkg::OP_RES_ABOVE;
          state_d = S_OUT;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: state_d = sts_i.bound_hit ? S_FTB : S_MBD;
      S_MBD: begin op_o = bra_pkg::OP_MUL_BD; state_d = S_MTB; end
      S_MTB: begin op_o = bra_pkg::OP_MUL_B;  state_d = S_MTD; end
      S_MTD: begin op_o = bra_pkg::OP_MUL_D;  state_d = S_GAP; end
      S_GAP: begin
        op_o    = bra_pkg::OP_GAP;
        state_d = sts_i.sign_exit ? S_RKP : S_MGM;
      end
      S_RKP: begin op_o = bra_pkg::OP_RES_KEPT; state_d = S_OUT; end
      S_MGM: begin op_o = bra_pkg::OP_MUL_GM;   state_d = S_TST; end
      S_TST: begin
        if (sts_i.small_gap) begin
          op_o    = bra_pkg::OP_RES_KEPT;
          state_d = S_OUT;
        end else begin
          op_o    = bra_pkg::OP_DIV_N;
          state_d = S_DWN;
        end
      end
      S_DWN: if (!sts_i.div_busy) state_d = S_DVC;
      S_DVC: begin op_o = bra_pkg::OP_DIV_CAP; state_d = S_DWC; end
      S_DWC: if (!sts_i.div_busy) state_d = S_CLP;
      S_CLP: begin op_o = bra_pkg::OP_CLAMP;    state_d = S_MNN; end
      S_MNN: begin op_o = bra_pkg::OP_MUL_NN;   state_d = S_ADN; end
      S_ADN: begin op_o = bra_pkg::OP_ADD_N;    state_d = S_ADD; end
      S_ADD: begin op_o = bra_pkg::OP_ADD_D;    state_d = S_CHK; end
      S_FTB: begin op_o = bra_pkg::OP_FIN_B;    state_d = S_FLO; end
      S_FLO: begin op_o = bra_pkg::OP_FIN_LO;   state_d = S_FHI; end
      S_FHI: begin op_o = bra_pkg::OP_FIN_HI;   state_d = S_FBC; end
      S_FBC: begin op_o = bra_pkg::OP_FIN_BC;   state_d = S_FAD; end
      S_FAD: begin op_o = bra_pkg::OP_FIN_AD;   state_d = S_FPK; end
      S_FPK: begin op_o = bra_pkg::OP_FIN_PICK; state_d = S_OUT; end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          op_o    = bra_pkg::OP_PUSH;
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output beat holding register valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (push)             ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

@@ rtl/best_rational_approximation.sv @@
// Each narrowing step runs the shared one-bit-per-cycle divider twice (run length and
// its cap). Out-of-range targets skip the narrowing and go straight to the output;
// the end pick builds both cross products on the shared multiplier, then compares.
// Throughput: one item at a time; the next item is taken as soon as a result is handed
// to the output register. Reset is asynchronous, active low: control returns to idle,
// the output is emptied and max_denominator returns to 1048575.
module best_rational_approximation (
  input  logic         clk_i,
  input  logic         rst_ni,
  // target[33:0], zero padded
  input  logic [39:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // numerator[29:0], denominator[59:30], iteration_count[66:60], status[68:67]
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [bra_pkg::DEN_W-1:0]  maxden_q;
  bra_pkg::status_t           sts;
  bra_pkg::op_e               op;
  logic [bra_pkg::DEN_W-1:0]  numerator, denominator;
  logic [bra_pkg::ITER_W-1:0] iteration_count;
  logic [1:0]                 status;

  // Config register
  assign pready = 1'b1;
  assign prdata = {2'b0, maxden_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxden_q <= bra_pkg::MAXDEN_RST;
    end else if (psel && penable && pwrite && pready && (paddr == bra_pkg::ADDR_MAXDEN)) begin
      maxden_q <= pwdata[bra_pkg::DEN_W-1:0];
    end
  end

  bra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .op_o        (op)
  );

  bra_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .target_i          (s_axis_tdata[bra_pkg::TGT_W-1:0]),
    .maxden_i          (maxden_q),
    .sts_o             (sts),
    .numerator_o       (numerator),
    .denominator_o     (denominator),
    .iteration_count_o (iteration_count),
    .status_o          (status)
  );

  assign m_axis_tdata = {3'b0, status, iteration_count, denominator, numerator};

  // Result sanity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (denominator != '0) && (numerator <= denominator))
    else $error("result fraction out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == bra_pkg::ST_BELOW)) |->
      (numerator == '0) && (iteration_count == '0))
    else $error("below-zero result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == bra_pkg::ST_LIMIT)) |->
      (iteration_count == bra_pkg::MAX_ITER + 7'd1))
    else $error("iteration limit status without limit count");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  // One expected output beat
  typedef struct {
    logic [bra_pkg::DEN_W-1:0]  num;
    logic [bra_pkg::DEN_W-1:0]  den;
    logic [bra_pkg::ITER_W-1:0] iters;
    logic [1:0]                 status;
  } fraction_t;

  // Predicts the best fraction for each accepted target, checks output beats in order
  class fraction_board;
    fraction_t   pending_q[$];
    logic [63:0] max_den;
    int          errors;

    function new();
      max_den = 64'(bra_pkg::MAXDEN_RST);
      errors  = 0;
    endfunction

    function void set_max_den(logic [bra_pkg::DEN_W-1:0] v);
      max_den = 64'(v);
    endfunction

    // Farey narrowing with exact products on target / 2^32
    function fraction_t approximate(logic [bra_pkg::TGT_W-1:0] target);
      fraction_t    r;
      logic [63:0]  m, a, b, c, d, ac, bd, n, cap, lim, step, ii;
      logic [127:0] one, tgt, lhs, rhs, tb_w, af, td, cf, g, h, q;
      bit           done;
      one  = 128'(1) << bra_pkg::FRAC_BITS;
      tgt  = 128'(target);
      m    = (max_den == 0) ? 64'd1 : max_den;
      a = 0; b = 1; c = 1; d = 1; ii = 0;
      r.status = bra_pkg::ST_OK;
      done = 0;
      if (target[bra_pkg::TGT_W-1]) begin
        r.num = '0; r.den = bra_pkg::DEN_W'(1); r.iters = '0; r.status = bra_pkg::ST_BELOW;
        return r;
      end
      if (tgt > one) begin
        r.num = bra_pkg::DEN_W'(1); r.den = bra_pkg::DEN_W'(1); r.iters = '0;
        r.status = bra_pkg::ST_ABOVE;
        return r;
      end
      while (!done) begin
        ac = a + c;
        bd = b + d;
        if (bd > m || ii > 64'(bra_pkg::MAX_ITER)) begin
          // Pick the closer endpoint, ties go to c/d
          lhs = tgt * 128'(b) * 128'(2 * d);
          rhs = 128'(b * c + a * d) * one;
          if (ii > 64'(bra_pkg::MAX_ITER)) r.status = bra_pkg::ST_LIMIT;
          if (lhs < rhs) begin
            r.num = a[bra_pkg::DEN_W-1:0]; r.den = b[bra_pkg::DEN_W-1:0];
          end else begin
            r.num = c[bra_pkg::DEN_W-1:0]; r.den = d[bra_pkg::DEN_W-1:0];
          end
          done = 1;
        end else begin
          tb_w = tgt * 128'(b);
          af   = 128'(a) * one;
          td   = tgt * 128'(d);
          cf   = 128'(c) * one;
          if (tgt * 128'(bd) < 128'(ac) * one) begin
            // Target left of mediant: keep a/b, pull c/d in
            if (tb_w < af) begin
              r.num = a[bra_pkg::DEN_W-1:0]; r.den = b[bra_pkg::DEN_W-1:0]; done = 1;
            end else begin
              g = tb_w - af;
              if (g * 128'(10 * m) < one) begin
                r.num = a[bra_pkg::DEN_W-1:0]; r.den = b[bra_pkg::DEN_W-1:0]; done = 1;
              end else begin
                h = (cf < td) ? 128'd0 : cf - td;
                lim = m - d; step = b;
              end
            end
          end else begin
            // Target right of mediant: keep c/d, push a/b up
            if (cf < td) begin
              r.num = c[bra_pkg::DEN_W-1:0]; r.den = d[bra_pkg::DEN_W-1:0]; done = 1;
            end else begin
              g = cf - td;
              if (g * 128'(10 * m) < one) begin
                r.num = c[bra_pkg::DEN_W-1:0]; r.den = d[bra_pkg::DEN_W-1:0]; done = 1;
              end else begin
                h = (tb_w < af) ? 128'd0 : tb_w - af;
                lim = m - b; step = d;
              end
            end
          end
          if (!done) begin
            q   = h / g;
            n   = (q[127:64] != 0) ? '1 : q[63:0];
            cap = lim / step;
            if (n < 1) n = 1;
            if (n > cap) n = cap;
            if (tgt * 128'(bd) < 128'(ac) * one) begin
              c = c + n * a; d = d + n * b;
            end else begin
              a = a + n * c; b = b + n * d;
            end
            ii = ii + 1;
          end
        end
      end
      r.iters = ii[bra_pkg::ITER_W-1:0];
      return r;
    endfunction

    function void note_target(logic [bra_pkg::TGT_W-1:0] target);
      pending_q.push_back(approximate(target));
    endfunction

    function void check_beat(logic [71:0] data);
      fraction_t e;
      if (pending_q.size() == 0) begin
        $error("output beat with nothing expected: %h", data);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (data[29:0] !== e.num) begin
        $error("numerator: expected %0d, got %0d", e.num, data[29:0]);
        errors++;
      end
      if (data[59:30] !== e.den) begin
        $error("denominator: expected %0d, got %0d", e.den, data[59:30]);
        errors++;
      end
      if (data[66:60] !== e.iters) begin
        $error("iteration_count: expected %0d, got %0d", e.iters, data[66:60]);
        errors++;
      end
      if (data[68:67] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, data[68:67]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fraction_board board;
  int            beats_out;

  best_rational_approximation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // APB write: setup then access
  task automatic write_max_den(logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bra_pkg::ADDR_MAXDEN; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_max_den(v[bra_pkg::DEN_W-1:0]);
  endtask

  // Offer one target beat, after a random gap unless no_gap is set
  task automatic send_target(logic [bra_pkg::TGT_W-1:0] t, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 40'(t);
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_target(t);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [bra_pkg::TGT_W-1:0] random_target();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return {2'b11, 32'($urandom)};
    if (sel == 1) return {2'b10, 32'($urandom)};
    if (sel == 2) return {2'b01, 32'($urandom)};
    if (sel == 3) return 34'h1_0000_0000;
    return {2'b00, 32'($urandom)};
  endfunction

  // Output side: random stalls plus one long hold-off
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    beats_out = 0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (beats_out == 40) gap = 400;
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_beat(m_axis_tdata);
      beats_out++;
    end
  end

  initial begin
    #300ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [bra_pkg::TGT_W-1:0] directed[$];
    logic [31:0]               den_set[$];
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: range edges, exact one, out of range both ways, awkward fractions
    directed = '{34'h0, 34'h1, 34'h1_0000_0000, 34'h1_0000_0001, 34'h1_FFFF_FFFF,
                 34'h2_0000_0000, 34'h3_FFFF_FFFF, 34'h0_8000_0000, 34'h0_FFFF_FFFF,
                 34'h0_9E37_79B9, 34'h0_5555_5555, 34'h0_243F_6A88, 34'h0_0000_0100,
                 34'h0_FFFF_FF00};
    foreach (directed[i]) send_target(directed[i], i < 4);
    drain();

    // Denominator bounds: minimum, zero, maximum, small, random, reset value
    den_set = '{32'd1, 32'd0, 32'd1073741823, $urandom_range(2, 200),
                32'($urandom_range(1, 1073741823)), 32'd1048575};
    foreach (den_set[p]) begin
      write_max_den(den_set[p]);
      repeat (2) @(negedge clk_i);
      for (int k = 0; k < ((p < 2) ? 25 : 55); k++) begin
        send_target(random_target());
        if (p == 3 && k == 20) drain();
      end
      drain();
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ best_rational_approximation.f @@
rtl/bra_pkg.sv
rtl/bra_div.sv
rtl/bra_dp.sv
rtl/bra_ctrl.sv
rtl/best_rational_approximation.sv
test/tb.sv
